FILE: rtl/core/dpda_pkg.sv
`timescale 1ns / 1ps
package dpda_pkg;

  localparam int unsigned MaxChunkBytes = 640;
  localparam int unsigned OffsetBits    = 24;
  localparam int unsigned CntW          = 12;
  localparam int unsigned SumW          = 16;

  // register indexes of the configuration port
  localparam logic [1:0] REG_DELIM0 = 2'd0;
  localparam logic [1:0] REG_DELIM1 = 2'd1;
  localparam logic [1:0] REG_DELIM2 = 2'd2;
  localparam logic [1:0] REG_JUMP   = 2'd3;

  // chunk status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LARGE   = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOT5    = 3'd3;
  localparam logic [2:0] ST_NOKEEP  = 3'd4;

  // one queue entry: a data byte for the chunk, or a chunk close
  typedef struct packed {
    logic       is_close;
    logic       final_rep;
    logic [7:0] data;
    logic [OffsetBits-1:0] next_start;
  } ev_t;

  // one finished chunk handed to the divider
  typedef struct packed {
    logic [15:0]           index;
    logic [OffsetBits-1:0] offset;
    logic [2:0]            status;
    logic [7:0]            kept;
    logic [7:0]            ignored;
    logic [SumW-1:0]       sum_x;
    logic [SumW-1:0]       sum_y;
    logic [SumW-1:0]       sum_z;
    logic                  final_rep;
  } rep_t;

endpackage

FILE: rtl/core/dpda_front.sv
`timescale 1ns / 1ps
// delimiter matcher: turns stream bytes into data and close events
module dpda_front import dpda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] d0_i,
  input  logic [7:0] d1_i,
  input  logic [7:0] d2_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output logic       ev_valid_o,
  output ev_t        ev_o,
  input  logic       ev_stall_i
);

  logic [7:0] win_q [3];
  logic [1:0] cnt_q, cnt_d;
  logic [OffsetBits-1:0] pos_q;
  // flush: emit leftover window bytes then close
  logic       flush_q, flush_d;
  logic [1:0] fidx_q, fidx_d;
  logic       busy_q, busy_d;
  ev_t        ev_q, ev_d;

  logic       take;
  logic       match;
  logic       out_free;
  logic [OffsetBits-1:0] pos_n;

  assign out_free   = !busy_q || !ev_stall_i;
  assign in_stall_o = flush_q || !out_free;
  assign take       = in_valid_i && !in_stall_o;
  assign pos_n      = pos_q + 1'b1;
  assign match      = (cnt_q == 2'd3) && (win_q[0] == d0_i) && (win_q[1] == d1_i) &&
                      (win_q[2] == d2_i) && (byte_i == (d0_i ^ d1_i ^ d2_i));

  // next event and control
  always_comb begin
    cnt_d   = cnt_q;
    flush_d = flush_q;
    fidx_d  = fidx_q;
    busy_d  = busy_q && ev_stall_i;
    ev_d    = ev_q;
    if (flush_q && out_free) begin
      busy_d = 1'b1;
      if (fidx_q < cnt_q) begin
        ev_d.is_close = 1'b0;
        ev_d.data     = win_q[fidx_q];
        fidx_d        = fidx_q + 1'b1;
      end else begin
        ev_d.is_close  = 1'b1;
        ev_d.final_rep = 1'b1;
        flush_d        = 1'b0;
        cnt_d          = 2'd0;
        fidx_d         = 2'd0;
      end
    end else if (take) begin
      ev_d.next_start = pos_n;
      ev_d.final_rep  = eos_i;
      if (match) begin
        busy_d        = 1'b1;
        ev_d.is_close = 1'b1;
        cnt_d         = 2'd0;
      end else if (cnt_q == 2'd3) begin
        busy_d        = 1'b1;
        ev_d.is_close = 1'b0;
        ev_d.data     = win_q[0];
        flush_d       = eos_i;
      end else begin
        cnt_d   = cnt_q + 1'b1;
        flush_d = eos_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pos_q   <= '0;
      flush_q <= 1'b0;
      fidx_q  <= '0;
      busy_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      fidx_q  <= fidx_d;
      busy_q  <= busy_d;
      if (take) pos_q <= eos_i ? '0 : pos_n;
    end
  end

  // window shift and event payload
  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    if (take && !match) begin
      if (cnt_q == 2'd3) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= byte_i;
      end else begin
        win_q[cnt_q] <= byte_i;
      end
    end
  end

  assign ev_valid_o = busy_q;
  assign ev_o       = ev_q;

endmodule

FILE: rtl/core/dpda_queue.sv
`timescale 1ns / 1ps
// small fifo between the matcher and the packet checker
module dpda_queue import dpda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  ev_t  wr_data_i,
  output logic rd_valid_o,
  input  logic rd_stall_i,
  output ev_t  rd_data_o
);

  ev_t        mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] lvl_q;
  logic       wr, rd;

  assign wr_stall_o = (lvl_q == 3'd4);
  assign rd_valid_o = (lvl_q != 3'd0);
  assign wr         = wr_valid_i && !wr_stall_o;
  assign rd         = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      lvl_q <= lvl_q + {2'b0, wr} - {2'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: rtl/core/dpda_back.sv
`timescale 1ns / 1ps
// packet assembly, checks, accumulation and chunk close
module dpda_back import dpda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] jump_i,
  input  logic       ev_valid_i,
  output logic       ev_stall_o,
  input  ev_t        ev_i,
  output logic       rep_valid_o,
  output rep_t       rep_o,
  input  logic       rep_stall_i
);

  logic [7:0]      pb_q [4];
  logic [2:0]      ppos_q;
  logic [CntW-1:0] bcnt_q;
  logic [SumW-1:0] sum_q [3];
  logic [7:0]      last_q [3];
  logic            have_q;
  logic [7:0]      kept_q, ign_q;
  logic [15:0]     idx_q;
  logic [OffsetBits-1:0] start_q;
  logic            rv_q;
  rep_t            rep_q;

  logic            take;
  logic [7:0]      c [3];
  logic            good, jump_ok;
  logic [7:0]      dif [3];
  logic [2:0]      st;

  assign ev_stall_o = rv_q && rep_stall_i && ev_i.is_close;
  assign take       = ev_valid_i && !ev_stall_o;

  // swizzle and checks on the fifth byte
  always_comb begin
    case (pb_q[3])
      8'd1:    begin c[0] = pb_q[0]; c[1] = pb_q[1]; c[2] = pb_q[2]; end
      8'd2:    begin c[0] = pb_q[0]; c[1] = pb_q[2]; c[2] = pb_q[1]; end
      8'd3:    begin c[0] = pb_q[1]; c[1] = pb_q[0]; c[2] = pb_q[2]; end
      8'd4:    begin c[0] = pb_q[2]; c[1] = pb_q[0]; c[2] = pb_q[1]; end
      8'd5:    begin c[0] = pb_q[1]; c[1] = pb_q[2]; c[2] = pb_q[0]; end
      default: begin c[0] = pb_q[2]; c[1] = pb_q[1]; c[2] = pb_q[0]; end
    endcase
    good = ((pb_q[0] ^ pb_q[1] ^ pb_q[2] ^ pb_q[3]) == ev_i.data) &&
           (pb_q[3] inside {[8'd1:8'd6]});
    jump_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dif[k] = (c[k] > last_q[k]) ? c[k] - last_q[k] : last_q[k] - c[k];
      if (have_q && dif[k] > jump_i) jump_ok = 1'b0;
    end
  end

  // packet position is the byte count modulo five below the size limit
  always_comb begin
    if (bcnt_q > CntW'(MaxChunkBytes))  st = ST_LARGE;
    else if (bcnt_q == '0)              st = ST_EMPTY;
    else if (ppos_q != '0)              st = ST_NOT5;
    else if (kept_q == '0)              st = ST_NOKEEP;
    else                                st = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppos_q  <= '0;
      bcnt_q  <= '0;
      have_q  <= 1'b0;
      kept_q  <= '0;
      ign_q   <= '0;
      idx_q   <= '0;
      start_q <= '0;
      rv_q    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        last_q[k] <= '0;
      end
    end else begin
      if (rv_q && !rep_stall_i) rv_q <= 1'b0;
      if (take && ev_i.is_close) begin
        rv_q    <= 1'b1;
        ppos_q  <= '0;
        bcnt_q  <= '0;
        have_q  <= 1'b0;
        kept_q  <= '0;
        ign_q   <= '0;
        idx_q   <= ev_i.final_rep ? '0 : idx_q + 1'b1;
        start_q <= ev_i.final_rep ? '0 : ev_i.next_start;
        for (int k = 0; k < 3; k++) begin
          sum_q[k]  <= '0;
          last_q[k] <= '0;
        end
      end else if (take) begin
        if (bcnt_q <= CntW'(MaxChunkBytes)) bcnt_q <= bcnt_q + 1'b1;
        if (ppos_q < 3'd4) begin
          ppos_q <= ppos_q + 1'b1;
        end else begin
          ppos_q <= '0;
          if (good && jump_ok) begin
            have_q <= 1'b1;
            if (kept_q != 8'hff) kept_q <= kept_q + 1'b1;
            for (int k = 0; k < 3; k++) begin
              sum_q[k]  <= sum_q[k] + SumW'(c[k]);
              last_q[k] <= c[k];
            end
          end else if (ign_q != 8'hff) begin
            ign_q <= ign_q + 1'b1;
          end
        end
      end
    end
  end

  // packet bytes and report payload
  always_ff @(posedge clk_i) begin
    if (take && !ev_i.is_close && ppos_q < 3'd4) pb_q[ppos_q[1:0]] <= ev_i.data;
    if (take && ev_i.is_close) begin
      rep_q.index     <= idx_q;
      rep_q.offset    <= start_q;
      rep_q.status    <= st;
      rep_q.kept      <= (st == ST_OK || st == ST_NOKEEP) ? kept_q : '0;
      rep_q.ignored   <= (st == ST_OK || st == ST_NOKEEP) ? ign_q : '0;
      rep_q.sum_x     <= sum_q[0];
      rep_q.sum_y     <= sum_q[1];
      rep_q.sum_z     <= sum_q[2];
      rep_q.final_rep <= ev_i.final_rep;
    end
  end

  assign rep_valid_o = rv_q;
  assign rep_o       = rep_q;

endmodule

FILE: rtl/core/dpda_div.sv
`timescale 1ns / 1ps
// restoring divider: three averages one bit per cycle, then the output register
module dpda_div import dpda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rep_valid_i,
  output logic        rep_stall_o,
  input  rep_t        rep_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rep_t        out_o,
  output logic [15:0] avg_x_o,
  output logic [15:0] avg_y_o,
  output logic [15:0] avg_z_o
);

  localparam int unsigned NumW = SumW + 8;

  logic [1:0]      st_q;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  rep_t            r_q;
  logic [NumW-1:0] num_q [3];
  logic [8:0]      rem_q [3];
  logic [15:0]     quo_q [3];
  logic [4:0]      step_q;
  logic [8:0]      rs [3];

  assign rep_stall_o = (st_q != S_IDLE);

  always_comb begin
    for (int k = 0; k < 3; k++) rs[k] = {rem_q[k][7:0], num_q[k][NumW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      step_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: if (rep_valid_i) begin
          st_q   <= (rep_i.status == ST_OK) ? S_DIV : S_OUT;
          step_q <= '0;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == 5'(NumW - 1)) st_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && rep_valid_i) begin
      r_q      <= rep_i;
      num_q[0] <= {rep_i.sum_x, 8'd0};
      num_q[1] <= {rep_i.sum_y, 8'd0};
      num_q[2] <= {rep_i.sum_z, 8'd0};
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (st_q == S_DIV) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= num_q[k] << 1;
        if (rs[k] >= {1'b0, r_q.kept}) begin
          rem_q[k] <= rs[k] - {1'b0, r_q.kept};
          quo_q[k] <= {quo_q[k][14:0], 1'b1};
        end else begin
          rem_q[k] <= rs[k];
          quo_q[k] <= {quo_q[k][14:0], 1'b0};
        end
      end
    end
  end

  assign out_valid_o = (st_q == S_OUT);
  assign out_o       = r_q;
  assign avg_x_o     = (r_q.status == ST_OK) ? quo_q[0] : '0;
  assign avg_y_o     = (r_q.status == ST_OK) ? quo_q[1] : '0;
  assign avg_z_o     = (r_q.status == ST_OK) ? quo_q[2] : '0;

endmodule

FILE: rtl/core/delimited_packet_deframer_averager.sv
`timescale 1ns / 1ps
// channel  | handshake                     | payload
// input    | in_valid_i / in_stall_o       | data_byte_i, end_of_stream_i
// report   | out_valid_o / out_stall_i     | chunk_* , *_packets_o, average_*_o
// config   | cfg_we_i                      | cfg_index_i, cfg_data_i
// a byte is taken each cycle while no end-of-stream flush is running and the event queue has room
// an ok report is divided in the averaging divider (one quotient bit a cycle)
// then held in its output register until taken; other reports skip the division
// end of stream flushes the delimiter window: its leftover bytes, then a final chunk close
// reset is asynchronous and clears all control state; jump limit resets to 25
// a stalled report backs up into the queue and then the byte input
module delimited_packet_deframer_averager import dpda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] chunk_index_o,
  output logic [23:0] chunk_offset_o,
  output logic [2:0]  chunk_status_o,
  output logic [7:0]  kept_packets_o,
  output logic [7:0]  ignored_packets_o,
  output logic [15:0] average_x_o,
  output logic [15:0] average_y_o,
  output logic [15:0] average_z_o,
  output logic        final_report_o
);

  logic [7:0] d0_q, d1_q, d2_q, jump_q;
  logic       fv, fs, qv, qs, rv, rs;
  ev_t        fe, qe;
  rep_t       rep, fin;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q   <= '0;
      d1_q   <= '0;
      d2_q   <= '0;
      jump_q <= 8'd25;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DELIM0: d0_q   <= cfg_data_i;
        REG_DELIM1: d1_q   <= cfg_data_i;
        REG_DELIM2: d2_q   <= cfg_data_i;
        REG_JUMP:   jump_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  dpda_front u_front (
    .clk_i, .rst_ni, .d0_i(d0_q), .d1_i(d1_q), .d2_i(d2_q),
    .in_valid_i, .in_stall_o, .byte_i(data_byte_i), .eos_i(end_of_stream_i),
    .ev_valid_o(fv), .ev_o(fe), .ev_stall_i(fs)
  );

  dpda_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_stall_o(fs), .wr_data_i(fe),
    .rd_valid_o(qv), .rd_stall_i(qs), .rd_data_o(qe)
  );

  dpda_back u_back (
    .clk_i, .rst_ni, .jump_i(jump_q), .ev_valid_i(qv), .ev_stall_o(qs), .ev_i(qe),
    .rep_valid_o(rv), .rep_o(rep), .rep_stall_i(rs)
  );

  dpda_div u_div (
    .clk_i, .rst_ni, .rep_valid_i(rv), .rep_stall_o(rs), .rep_i(rep),
    .out_valid_o, .out_stall_i, .out_o(fin),
    .avg_x_o(average_x_o), .avg_y_o(average_y_o), .avg_z_o(average_z_o)
  );

  assign chunk_index_o     = fin.index;
  assign chunk_offset_o    = fin.offset;
  assign chunk_status_o    = fin.status;
  assign kept_packets_o    = fin.kept;
  assign ignored_packets_o = fin.ignored;
  assign final_report_o    = fin.final_rep;

endmodule

FILE: rtl/core/dpda_checker.sv
`timescale 1ns / 1ps
// port level checks
module dpda_checker import dpda_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  chunk_status_o,
  input logic [7:0]  kept_packets_o,
  input logic [15:0] average_x_o
);

  // stalled report holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chunk_status_o))
    else $error("report dropped under stall");

  // status in range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chunk_status_o <= ST_NOKEEP)
    else $error("bad status");

  // ok status has kept packets
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_status_o == ST_OK |-> kept_packets_o != 8'd0)
    else $error("ok without kept packet");

  // only ok status shows averages
  a_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_status_o != ST_OK |-> average_x_o == 16'd0)
    else $error("average on error status");

endmodule

bind delimited_packet_deframer_averager dpda_checker u_dpda_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .chunk_status_o,
  .kept_packets_o, .average_x_o
);
